>>> rtl/core/diff_biphase_ask_demodulator_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the differential biphase demodulator
// Clocked on clk and disabled while arst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef DIFF_BIPHASE_ASK_DEMODULATOR_UNIT_DEFINES_SVH
`define DIFF_BIPHASE_ASK_DEMODULATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define DBAD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("dbad assertion failed");
// A condition that must never be seen at a clock edge outside reset.
`define DBAD_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("dbad forbidden condition seen");
`else
`define DBAD_ASSERT(label, prop)
`define DBAD_NEVER(label, cond)
`endif

`endif

>>> rtl/core/dbad_pkg.sv
// ----------------------------------------------------------------------------
// dbad_pkg
// Types and constants of the differential biphase demodulator.
// ----------------------------------------------------------------------------
package dbad_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [4:0] idx_t;
	typedef logic [1:0] rx_state_t;

	localparam rx_state_t RX_IDLE     = 2'd0;
	localparam rx_state_t RX_PREAMBLE = 2'd1;
	localparam rx_state_t RX_DATA     = 2'd2;

	// Register word index of the preamble length register.
	localparam logic REG_PREAMBLE = 1'b0;

	localparam logic [4:0] PREAMBLE_RESET = 5'd11;
	localparam logic [4:0] BYTE_BITS      = 5'd8;
	localparam int         MIN_BYTES      = 2;

endpackage

>>> rtl/core/dbad_if.sv
// ----------------------------------------------------------------------------
// dbad channel interfaces
// Valid/ready channels for line samples and decoded results.
// ----------------------------------------------------------------------------
interface dbad_in_if;
	logic valid;
	logic ready;
	logic level;

	modport source (output valid, output level, input ready);
	modport sink (input valid, input level, output ready);
endinterface

interface dbad_out_if import dbad_pkg::*; ();
	logic      valid;
	logic      ready;
	logic      byte_valid;
	byte_t     byte_value;
	idx_t      byte_index;
	logic      packet_ok;
	logic      pkt_ready;
	logic      frame_abort;
	rx_state_t rx_state;

	modport source (output valid, output byte_valid, output byte_value, output byte_index,
		output packet_ok, output pkt_ready, output frame_abort, output rx_state,
		input ready);
	modport sink (input valid, input byte_valid, input byte_value, input byte_index,
		input packet_ok, input pkt_ready, input frame_abort, input rx_state,
		output ready);
endinterface

>>> rtl/core/diff_biphase_ask_demodulator_unit.sv
// ----------------------------------------------------------------------------
// diff_biphase_ask_demodulator_unit
// Differential biphase decoder: one line sample per beat, one result per beat.
// ----------------------------------------------------------------------------
// The result of a sample is registered and presented in the cycle after its beat.
// Throughput: one sample per cycle while results.ready holds; the decoder state is updated in a single
// pass of logic into the receiver registers and the result register.
// Reset: arst_n clears the receiver to idle, the result register to empty and
// the preamble length register to 11.
`include "diff_biphase_ask_demodulator_unit_defines.svh"

module diff_biphase_ask_demodulator_unit import dbad_pkg::*; #(
	parameter int MAX_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	dbad_in_if.sink     samples,
	dbad_out_if.source  results,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CNT_W = $clog2(MAX_BYTES + 1);

	// Configuration register
	logic [4:0] preamble_q;
	logic       cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_PREAMBLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q <= PREAMBLE_RESET;
		end else if (cfg_write) begin
			preamble_q <= pwdata[4:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PREAMBLE) begin
			prdata[4:0] = preamble_q;
		end
	end

	// Receiver state
	rx_state_t        state_q, state_n;
	logic             prev_q, prev_n;
	logic             mid_q, mid_n;
	logic [4:0]       bitcnt_q, bitcnt_n;
	byte_t            shift_q, shift_n;
	logic [CNT_W-1:0] count_q, count_n;
	byte_t            parity_q, parity_n;
	logic             ready_q, ready_n;

	// Result of the current sample
	logic             r_byte_valid;
	byte_t            r_byte_value;
	idx_t             r_byte_index;
	logic             r_ok;
	logic             r_abort;

	logic             accept;
	logic             edge_seen;
	logic             bit_val;
	logic [4:0]       bitcnt_inc;
	byte_t            shift_in;
	logic [CNT_W+4:0] count_wide;

	assign accept     = samples.valid && samples.ready;
	assign edge_seen  = samples.level != prev_q;
	assign bit_val    = !edge_seen;
	assign bitcnt_inc = bitcnt_q + 5'd1;
	assign shift_in   = {shift_q[6:0], bit_val};
	assign count_wide = {5'd0, count_q};

	always_comb begin
		state_n      = state_q;
		prev_n       = samples.level;
		mid_n        = mid_q;
		bitcnt_n     = bitcnt_q;
		shift_n      = shift_q;
		count_n      = count_q;
		parity_n     = parity_q;
		ready_n      = ready_q;
		r_byte_valid = 1'b0;
		r_byte_value = '0;
		r_byte_index = '0;
		r_ok         = 1'b0;
		r_abort      = 1'b0;

		if (!mid_q) begin
			if (state_q == RX_IDLE) begin
				if (edge_seen) begin
					state_n  = RX_PREAMBLE;
					bitcnt_n = '0;
					count_n  = '0;
					shift_n  = '0;
					parity_n = '0;
					mid_n    = 1'b1;
				end
			end else if (!edge_seen) begin
				// Missing boundary edge: drop the frame and the sticky flag.
				state_n  = RX_IDLE;
				prev_n   = 1'b0;
				mid_n    = 1'b0;
				bitcnt_n = '0;
				shift_n  = '0;
				count_n  = '0;
				parity_n = '0;
				ready_n  = 1'b0;
				r_abort  = 1'b1;
			end else begin
				mid_n = 1'b1;
			end
		end else begin
			mid_n = 1'b0;
			if (state_q == RX_PREAMBLE) begin
				if (bit_val) begin
					bitcnt_n = bitcnt_inc;
					if (bitcnt_inc >= preamble_q) begin
						state_n  = RX_DATA;
						bitcnt_n = '0;
						shift_n  = '0;
					end
				end else begin
					bitcnt_n = '0;
				end
			end else begin
				shift_n  = shift_in;
				bitcnt_n = bitcnt_inc;
				if (bitcnt_inc >= BYTE_BITS) begin
					// Bytes past the buffer limit are dropped but the check still runs.
					if (count_q < CNT_W'(MAX_BYTES)) begin
						r_byte_valid = 1'b1;
						r_byte_value = shift_in;
						r_byte_index = count_wide[4:0];
						parity_n     = parity_q ^ shift_in;
						count_n      = count_q + CNT_W'(1);
					end
					bitcnt_n = '0;
					shift_n  = '0;
					if ((count_n >= CNT_W'(MIN_BYTES)) && (parity_n == '0)) begin
						ready_n = 1'b1;
						state_n = RX_IDLE;
						r_ok    = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= RX_IDLE;
			prev_q   <= 1'b0;
			mid_q    <= 1'b0;
			bitcnt_q <= '0;
			shift_q  <= '0;
			count_q  <= '0;
			parity_q <= '0;
			ready_q  <= 1'b0;
		end else if (accept) begin
			state_q  <= state_n;
			prev_q   <= prev_n;
			mid_q    <= mid_n;
			bitcnt_q <= bitcnt_n;
			shift_q  <= shift_n;
			count_q  <= count_n;
			parity_q <= parity_n;
			ready_q  <= ready_n;
		end
	end

	// Result register; a new sample is taken whenever it is empty or draining.
	logic      res_valid_q;
	logic      byte_valid_q;
	byte_t     byte_value_q;
	idx_t      byte_index_q;
	logic      ok_q;
	logic      ready_flag_q;
	logic      abort_q;
	rx_state_t rx_state_q;

	assign samples.ready = !res_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_valid_q <= r_byte_valid;
			byte_value_q <= r_byte_value;
			byte_index_q <= r_byte_index;
			ok_q         <= r_ok;
			ready_flag_q <= ready_n;
			abort_q      <= r_abort;
			rx_state_q   <= state_n;
		end
	end

	assign results.valid       = res_valid_q;
	assign results.byte_valid  = byte_valid_q;
	assign results.byte_value  = byte_value_q;
	assign results.byte_index  = byte_index_q;
	assign results.packet_ok   = ok_q;
	assign results.pkt_ready   = ready_flag_q;
	assign results.frame_abort = abort_q;
	assign results.rx_state    = rx_state_q;

	// A good packet and an abort cannot come from the same sample.
	`DBAD_NEVER(a_ok_and_abort, res_valid_q && ok_q && abort_q)
	// An abort always clears the sticky flag and returns to idle.
	`DBAD_ASSERT(a_abort_clears, (res_valid_q && abort_q) |-> (!ready_flag_q && (rx_state_q == RX_IDLE)))
	// The stored byte count never passes the buffer limit.
	`DBAD_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_BYTES))
	// A good packet leaves the receiver idle with the flag set.
	`DBAD_ASSERT(a_ok_idle, accept && r_ok |=> (state_q == RX_IDLE) && ready_q)

endmodule
